@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by sliding_window_average_xyz
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition c in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: implication");

// condition a implies condition c in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: next cycle");

`endif

@@ rtl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// types and constants of the sliding window average block
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int COORD_W         = 32;
   localparam int WINDOW_SIZE_W   = 5;
   localparam int ATOM_COUNT_W    = 11;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int STEPS_PER_STAGE = 4;

   localparam logic [WINDOW_SIZE_W-1:0] WINDOW_RESET = 5'd5;
   localparam logic [ATOM_COUNT_W-1:0]  ATOMS_RESET  = 11'd1;

   localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
   localparam logic [0:0] REG_ATOM_COUNT  = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] avg_x;
      logic signed [COORD_W-1:0] avg_y;
      logic signed [COORD_W-1:0] avg_z;
      logic                      last_atom;
   } rsp_type;

endpackage

@@ rtl/sliding_window_average_xyz.sv @@
// result path: read-modify-write stage, sum register, divider stages, then the output queue
// throughput: one transaction per cycle if req_ready is high, set by the single read-modify-write
//    pass on the window and sum memories; the divider is fully pipelined at 4 quotient bits per stage
// reset: synchronous; counters, pipeline and output queue clear, memories are not cleared
//    (the first frame after reset or a register write ignores the stored sums)
// ----------------------------------------------------------------------------
// sliding_window_average_xyz
// boxcar average of atom coordinates over the last window_size frames
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_average_xyz #(
   parameter int WINDOW_MAX = 16,
   parameter int MAX_ATOMS  = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  swa_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output swa_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [swa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [swa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int CW      = swa_pkg::COORD_W;
   localparam int DIV_W   = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int ATOM_W  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int ACNT_W  = $clog2(MAX_ATOMS + 1);
   localparam int SUM_W   = CW + $clog2(WINDOW_MAX) + ((FRAC_BITS > 0) ? 0 : 0);
   localparam int SPS     = swa_pkg::STEPS_PER_STAGE;
   localparam int NSTG    = (SUM_W + SPS - 1) / SPS;
   localparam int DQ_W    = NSTG * SPS;
   localparam int ACC_W   = DIV_W + DQ_W;
   localparam int FIFO_AW = $clog2(NSTG + 5);
   localparam int FIFO_D  = 2 ** FIFO_AW;
   localparam int CRED_W  = FIFO_AW + 1;
   localparam int WADDR_W = SLOT_W + ATOM_W;

   // configuration
   logic [swa_pkg::WINDOW_SIZE_W-1:0] window_size_ff;
   logic [swa_pkg::ATOM_COUNT_W-1:0]  atom_count_ff;
   logic                              cfg_wr;
   logic [DIV_W-1:0]                  ws_eff;
   logic [ACNT_W-1:0]                 ac_eff;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[swa_pkg::CSR_ADDR_W-1:2])
         swa_pkg::REG_WINDOW_SIZE:
            prdata = {{(swa_pkg::CSR_DATA_W-swa_pkg::WINDOW_SIZE_W){1'b0}}, window_size_ff};
         swa_pkg::REG_ATOM_COUNT:
            prdata = {{(swa_pkg::CSR_DATA_W-swa_pkg::ATOM_COUNT_W){1'b0}}, atom_count_ff};
         default: prdata = '0;
      endcase
   end

   always_comb begin
      if (window_size_ff == '0) begin
         ws_eff = DIV_W'(1);
      end else if (32'(window_size_ff) > 32'(WINDOW_MAX)) begin
         ws_eff = DIV_W'(WINDOW_MAX);
      end else begin
         ws_eff = DIV_W'(window_size_ff);
      end
      if (atom_count_ff == '0) begin
         ac_eff = ACNT_W'(1);
      end else if (32'(atom_count_ff) > 32'(MAX_ATOMS)) begin
         ac_eff = ACNT_W'(MAX_ATOMS);
      end else begin
         ac_eff = ACNT_W'(atom_count_ff);
      end
   end

   // stream position
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ATOM_W-1:0]  atom_ff, atom_in;
   logic [DIV_W-1:0]   frames_ff, frames_in;
   logic               req_fire, rsp_fire;
   logic               in_last, in_emit, in_sub, in_first;
   logic [WADDR_W-1:0] in_waddr;
   logic [CRED_W-1:0]  cred_ff, cred_in;

   assign req_fire = req_valid && req_ready;
   assign req_ready = cred_ff < CRED_W'(FIFO_D);
   assign in_last  = (ACNT_W'(atom_ff) + ACNT_W'(1)) == ac_eff;
   assign in_emit  = ({1'b0, frames_ff} + (DIV_W+1)'(1)) >= {1'b0, ws_eff};
   assign in_sub   = frames_ff >= ws_eff;
   assign in_first = frames_ff == '0;
   assign in_waddr = {slot_ff, atom_ff};

   always_comb begin
      slot_in   = slot_ff;
      atom_in   = atom_ff;
      frames_in = frames_ff;
      if (cfg_wr) begin
         slot_in   = '0;
         atom_in   = '0;
         frames_in = '0;
      end else if (req_fire) begin
         if (in_last) begin
            atom_in = '0;
            if ((DIV_W'(slot_ff) + DIV_W'(1)) >= ws_eff) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
            if (frames_ff < ws_eff) begin
               frames_in = frames_ff + DIV_W'(1);
            end
         end else begin
            atom_in = atom_ff + ATOM_W'(1);
         end
      end
      cred_in = cred_ff;
      if (req_fire && in_emit && !rsp_fire) begin
         cred_in = cred_ff + CRED_W'(1);
      end else if (rsp_fire && !(req_fire && in_emit)) begin
         cred_in = cred_ff - CRED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swa_pkg::WINDOW_RESET;
         atom_count_ff  <= swa_pkg::ATOMS_RESET;
         slot_ff        <= '0;
         atom_ff        <= '0;
         frames_ff      <= '0;
         cred_ff        <= '0;
      end else begin
         if (cfg_wr && paddr[swa_pkg::CSR_ADDR_W-1:2] == swa_pkg::REG_WINDOW_SIZE) begin
            window_size_ff <= pwdata[swa_pkg::WINDOW_SIZE_W-1:0];
         end
         if (cfg_wr && paddr[swa_pkg::CSR_ADDR_W-1:2] == swa_pkg::REG_ATOM_COUNT) begin
            atom_count_ff <= pwdata[swa_pkg::ATOM_COUNT_W-1:0];
         end
         slot_ff   <= slot_in;
         atom_ff   <= atom_in;
         frames_ff <= frames_in;
         cred_ff   <= cred_in;
      end
   end

   // memories
   logic [3*CW-1:0]    win_mem [2**WADDR_W];
   logic [3*SUM_W-1:0] sum_mem [2**ATOM_W];
   logic [3*CW-1:0]    win_rd_ff;
   logic [3*SUM_W-1:0] sum_rd_ff;

   // read-modify-write stage
   logic               s1_vld_ff, s1_first_ff, s1_sub_ff, s1_emit_ff, s1_last_ff;
   logic               s1_sfwd_ff, s1_wfwd_ff;
   logic [ATOM_W-1:0]  s1_atom_ff;
   logic [WADDR_W-1:0] s1_waddr_ff;
   logic [3*CW-1:0]    s1_coord_ff;
   logic [3*CW-1:0]    wb_win_ff;
   logic [3*SUM_W-1:0] new_sum;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_rd_ff <= win_mem[in_waddr];
         sum_rd_ff <= sum_mem[atom_ff];
      end
      if (s1_vld_ff) begin
         win_mem[s1_waddr_ff] <= s1_coord_ff;
         sum_mem[s1_atom_ff]  <= new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
      end
      if (req_fire) begin
         s1_first_ff <= in_first;
         s1_sub_ff   <= in_sub;
         s1_emit_ff  <= in_emit;
         s1_last_ff  <= in_last;
         s1_atom_ff  <= atom_ff;
         s1_waddr_ff <= in_waddr;
         s1_coord_ff <= req_data;
         s1_sfwd_ff  <= s1_vld_ff && (s1_atom_ff == atom_ff);
         s1_wfwd_ff  <= s1_vld_ff && (s1_waddr_ff == in_waddr);
      end
      if (s1_vld_ff) begin
         wb_win_ff <= s1_coord_ff;
      end
   end

   logic [3*SUM_W-1:0] sum_ff;
   logic               s2_vld_ff, s2_last_ff;

   always_comb begin
      logic signed [SUM_W-1:0] old_s;
      logic signed [SUM_W-1:0] old_w;
      logic signed [CW-1:0]    w32;
      logic signed [CW-1:0]    v32;
      for (int c = 0; c < 3; c++) begin
         if (s1_first_ff) begin
            old_s = '0;
         end else if (s1_sfwd_ff) begin
            old_s = sum_ff[c*SUM_W +: SUM_W];
         end else begin
            old_s = sum_rd_ff[c*SUM_W +: SUM_W];
         end
         w32 = s1_wfwd_ff ? wb_win_ff[c*CW +: CW] : win_rd_ff[c*CW +: CW];
         old_w = s1_sub_ff ? SUM_W'(w32) : '0;
         v32 = s1_coord_ff[c*CW +: CW];
         new_sum[c*SUM_W +: SUM_W] = old_s - old_w + SUM_W'(v32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff && s1_emit_ff;
      end
      if (s1_vld_ff) begin
         sum_ff     <= new_sum;
         s2_last_ff <= s1_last_ff;
      end
   end

   // divider pipeline
   function automatic logic [ACC_W-1:0] div_steps(input logic [ACC_W-1:0] acc,
                                                 input logic [DIV_W-1:0] d);
      logic [ACC_W:0]   sh;
      logic [DIV_W:0]   hi;
      logic [ACC_W-1:0] a;
      a = acc;
      for (int k = 0; k < SPS; k++) begin
         sh = {a, 1'b0};
         hi = sh[ACC_W:DQ_W];
         if (hi >= {1'b0, d}) begin
            hi = hi - {1'b0, d};
            sh[0] = 1'b1;
         end
         a = {hi[DIV_W-1:0], sh[DQ_W-1:0]};
      end
      return a;
   endfunction

   logic [ACC_W-1:0] acc_ff  [NSTG+1][3];
   logic [2:0]       neg_ff  [NSTG+1];
   logic             dlast_ff[NSTG+1];
   logic             dvld_ff [NSTG+1];

   always_ff @(posedge clock) begin
      logic signed [SUM_W-1:0] s;
      if (reset) begin
         for (int k = 0; k <= NSTG; k++) begin
            dvld_ff[k] <= 1'b0;
         end
      end else begin
         dvld_ff[0] <= s2_vld_ff;
         for (int k = 0; k < NSTG; k++) begin
            dvld_ff[k+1] <= dvld_ff[k];
         end
      end
      for (int c = 0; c < 3; c++) begin
         s = sum_ff[c*SUM_W +: SUM_W];
         neg_ff[0][c] <= s[SUM_W-1];
         acc_ff[0][c] <= {{DIV_W{1'b0}}, DQ_W'(s[SUM_W-1] ? -s : s)};
      end
      dlast_ff[0] <= s2_last_ff;
      for (int k = 0; k < NSTG; k++) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[k+1][c] <= div_steps(acc_ff[k][c], ws_eff);
         end
         neg_ff[k+1]   <= neg_ff[k];
         dlast_ff[k+1] <= dlast_ff[k];
      end
   end

   // output queue
   swa_pkg::rsp_type     fifo_mem [FIFO_D];
   logic [FIFO_AW:0]     wr_ptr_ff, rd_ptr_ff;
   logic [3*CW-1:0]      q_out;

   always_comb begin
      logic [CW-1:0] q;
      for (int c = 0; c < 3; c++) begin
         q = acc_ff[NSTG][c][CW-1:0];
         q_out[c*CW +: CW] = neg_ff[NSTG][c] ? -q : q;
      end
   end

   assign rsp_valid = wr_ptr_ff != rd_ptr_ff;
   assign rsp_data  = fifo_mem[rd_ptr_ff[FIFO_AW-1:0]];
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (dvld_ff[NSTG]) begin
            wr_ptr_ff <= wr_ptr_ff + (FIFO_AW+1)'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + (FIFO_AW+1)'(1);
         end
      end
      if (dvld_ff[NSTG]) begin
         fifo_mem[wr_ptr_ff[FIFO_AW-1:0]] <= {q_out, dlast_ff[NSTG]};
      end
   end

   // checks
   `ASSERT_IMPLIES(a_credit_bound, clock, reset, 1'b1, cred_ff <= CRED_W'(FIFO_D))
   `ASSERT_IMPLIES(a_rsp_has_credit, clock, reset, rsp_valid, cred_ff != '0)
   `ASSERT_IMPLIES(a_queue_in_credit, clock, reset, 1'b1,
      CRED_W'(wr_ptr_ff - rd_ptr_ff) <= cred_ff)
   `ASSERT_NEXT(a_frame_wrap, clock, reset, req_fire && in_last && !cfg_wr, atom_ff == '0)

endmodule
